@@ hdl/masked_boxcar_smoother_unit_assert.svh @@
// Assertion macros for the boxcar smoother
`ifndef MASKED_BOXCAR_SMOOTHER_UNIT_ASSERT_SVH
`define MASKED_BOXCAR_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication
`define MBS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mbs_pkg.sv @@
package mbs_pkg;

   localparam int QUAL_W = 8;
   localparam int POS_W  = 24;
   localparam int WIN_W  = 7;
   localparam int CSR_W  = 24;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_SERIES_LENGTH = 2'd1,
      CSR_QUALITY_MASK  = 2'd2,
      CSR_USE_QUALITY   = 2'd3
   } csr_index_type;

endpackage

@@ hdl/mbs_req_if.sv @@
interface mbs_req_if
   import mbs_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic [QUAL_W-1:0]             quality_byte;
   logic                          sample_bad;

   modport source (output valid, sample_value, quality_byte, sample_bad, input ready);
   modport sink (input valid, sample_value, quality_byte, sample_bad, output ready);
endinterface

@@ hdl/mbs_rsp_if.sv @@
interface mbs_rsp_if
   import mbs_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] smoothed_value;
   logic [POS_W-1:0]              position;
   logic                          last_of_run;
   logic                          length_error;

   modport source (output valid, smoothed_value, position, last_of_run, length_error,
                   input ready);
   modport sink (input valid, smoothed_value, position, last_of_run, length_error,
                 output ready);
endinterface

@@ hdl/masked_boxcar_smoother_unit.sv @@
// Masked boxcar smoother.
// req_if: one sample per transfer (value, quality byte, bad flag). rsp_if: results
// carrying the smoothed or passed-through value, its series position, a last flag on
// the final position of the series and a length error flag.
// csr_*: register writes (window, series length, quality mask, quality select); any
// write restarts the series. Write only while the block is idle.
// Samples sit in a sample memory with one write and one read port (registered read); good bits, the window
// sum and the good count sit in flip-flops.
// A sample that emits nothing returns to idle without a divide; one that emits a mean
// runs the serial divider, which sets how long it takes. The last sample of a series
// flushes up to window/2 + 1 positions, each with at most one divide plus memory reads.
// req_if.ready is high only while the sequencer is idle; one result waits in the
// output register while the next sample is taken, and the sequencer holds when the
// receiver stalls with a result still pending.
// Reset is synchronous: registers return to their reset values, the series restarts,
// no memory clearing is needed.
module masked_boxcar_smoother_unit
   import mbs_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   mbs_req_if.sink              req_if,
   mbs_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int RW    = $clog2(MAX_WINDOW);
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int DCW   = $clog2(SUM_W + 1);

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_TRD  = 11'b00000000010,
      S_PASS = 11'b00000000100,
      S_DIV  = 11'b00000001000,
      S_OUT  = 11'b00000010000,
      S_RMV  = 11'b00000100000,
      S_SUB  = 11'b00001000000,
      F_EVAL = 11'b00010000000,
      F_SUB  = 11'b00100000000,
      F_EMIT = 11'b01000000000,
      F_NEXT = 11'b10000000000
   } state_type;

   function automatic logic [RW-1:0] ring_back(input logic [RW-1:0] ptr,
                                               input logic [CW-1:0] k);
      logic [CW:0] pe;
      logic [CW:0] res;
      pe = (CW+1)'(ptr);
      if (pe >= (CW+1)'(k)) res = pe - (CW+1)'(k);
      else res = pe + (CW+1)'(MAX_WINDOW) - (CW+1)'(k);
      return res[RW-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] sext(input logic [SAMPLE_BITS-1:0] v);
      return {{(SUM_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
   endfunction

   state_type state_ff;

   // configuration
   logic [WIN_W-1:0]  window_ff;
   logic [POS_W-1:0]  series_ff;
   logic [QUAL_W-1:0] qmask_ff;
   logic              use_q_ff;

   // series state
   logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic [MAX_WINDOW-1:0]  good_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CW-1:0]          count_ff;
   logic [POS_W-1:0]       index_ff;
   logic [POS_W-1:0]       next_emit_ff;
   logic [RW-1:0]          wr_ptr_ff;

   // per-item context
   logic [CW-1:0]          w_ff;
   logic [POS_W-1:0]       n_ff;
   logic [RW-1:0]          cur_ptr_ff;
   logic [RW-1:0]          t_slot_ff;
   logic [POS_W-1:0]       start_ff;
   logic                   rmv_en_ff;
   logic                   triv_ff;
   logic                   flush_ff;
   logic [CW-1:0]          d_ff;
   logic                   snap_v_ff;
   logic signed [SUM_W-1:0] snap_s_ff;
   logic [CW-1:0]          snap_c_ff;

   // divider
   logic [SUM_W-1:0] div_quo_ff;
   logic [CW-1:0]    div_rem_ff;
   logic [CW-1:0]    div_den_ff;
   logic             div_neg_ff;
   logic [DCW-1:0]   div_cnt_ff;

   // result being built
   logic [SAMPLE_BITS-1:0] res_val_ff;
   logic [POS_W-1:0]       res_pos_ff;
   logic                   res_last_ff;
   logic                   res_err_ff;

   // output register
   logic [SAMPLE_BITS-1:0] out_val_ff;
   logic [POS_W-1:0]       out_pos_ff;
   logic                   out_last_ff;
   logic                   out_err_ff;
   logic                   rsp_valid_ff;

   // accept-side decode
   logic [CW-1:0]    w_eff;
   logic [POS_W-1:0] n_eff;
   logic             good;
   logic [POS_W+1:0] i_x;
   logic [POS_W+1:0] w_x;
   logic [POS_W+1:0] t_i;
   logic [POS_W+1:0] t_n;
   logic             early;
   logic             last;
   logic             trivial;
   logic             len_err;
   logic [POS_W-1:0] start_base;
   logic             accept;

   always_comb begin
      if (window_ff == '0) w_eff = CW'(1);
      else if (window_ff > WIN_W'(MAX_WINDOW)) w_eff = CW'(MAX_WINDOW);
      else w_eff = CW'(window_ff);
      n_eff   = (series_ff == '0) ? POS_W'(1) : series_ff;
      good    = use_q_ff ? ((req_if.quality_byte & qmask_ff) == '0) : !req_if.sample_bad;
      i_x     = (POS_W+2)'(index_ff);
      w_x     = (POS_W+2)'(w_eff);
      early   = (i_x + 1) < w_x;
      t_i     = early ? ((i_x + 1) >> 1) : (i_x - (w_x >> 1));
      t_n     = ((i_x + 1) < (w_x - 1)) ? ((i_x + 2) >> 1) : (i_x + 1 - (w_x >> 1));
      last    = (i_x + 1) >= (POS_W+2)'(n_eff);
      trivial = (w_eff == CW'(1)) || (n_eff <= POS_W'(1)) || (w_x > (POS_W+2)'(n_eff));
      len_err = (w_eff > CW'(1)) && (n_eff > POS_W'(1)) && (w_x > (POS_W+2)'(n_eff));
      start_base = n_eff - POS_W'(1) - POS_W'(w_eff >> 1);
   end

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   // flush-side decode
   logic [CW-1:0]    f_m;
   logic [POS_W-1:0] f_p;
   logic [RW-1:0]    f_p_slot;
   logic [RW-1:0]    f_d_slot;
   logic [RW-1:0]    r_slot;
   logic             f_cond;
   logic             f_complete;

   always_comb begin
      f_m        = CW'((CW+1)'(d_ff) + 1 >> 1);
      f_p        = n_ff - POS_W'(1) - POS_W'(f_m);
      f_p_slot   = ring_back(cur_ptr_ff, f_m);
      f_d_slot   = ring_back(cur_ptr_ff, d_ff);
      r_slot     = ring_back(cur_ptr_ff, w_ff - CW'(1));
      f_cond     = (count_ff > CW'(1)) && good_ff[f_p_slot];
      f_complete = d_ff[0] || (d_ff == '0);
   end

   // sample memory, one write and one read per cycle
   logic [RW-1:0] rd_addr;
   always_comb begin
      unique case (state_ff)
         S_TRD:   rd_addr = t_slot_ff;
         S_RMV:   rd_addr = r_slot;
         F_EVAL:  rd_addr = f_d_slot;
         F_EMIT:  rd_addr = f_p_slot;
         default: rd_addr = t_slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && !trivial) begin
         ring_mem[wr_ptr_ff] <= req_if.sample_value;
      end
      rdata_ff <= ring_mem[rd_addr];
   end

   // divider step
   logic [CW:0]      div_trial;
   logic [SUM_W-1:0] div_res;
   assign div_trial = {div_rem_ff, div_quo_ff[SUM_W-1]} - {1'b0, div_den_ff};
   assign div_res   = div_neg_ff ? (SUM_W'(0) - div_quo_ff) : div_quo_ff;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WIN_W'(2);
         series_ff    <= '0;
         qmask_ff     <= '0;
         use_q_ff     <= 1'b0;
         good_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         index_ff     <= '0;
         next_emit_ff <= '0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         triv_ff      <= 1'b0;
         flush_ff     <= 1'b0;
         snap_v_ff    <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            out_val_ff   <= res_val_ff;
            out_pos_ff   <= res_pos_ff;
            out_last_ff  <= res_last_ff;
            out_err_ff   <= res_err_ff;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_WINDOW_LENGTH: window_ff <= csr_data[WIN_W-1:0];
               CSR_SERIES_LENGTH: series_ff <= csr_data[POS_W-1:0];
               CSR_QUALITY_MASK:  qmask_ff  <= csr_data[QUAL_W-1:0];
               CSR_USE_QUALITY:   use_q_ff  <= csr_data[0];
               default: ;
            endcase
            good_ff      <= '0;
            sum_ff       <= '0;
            count_ff     <= '0;
            index_ff     <= '0;
            next_emit_ff <= '0;
            wr_ptr_ff    <= '0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  w_ff      <= w_eff;
                  n_ff      <= n_eff;
                  index_ff  <= last ? '0 : POS_W'(i_x + 1);
                  triv_ff   <= trivial;
                  flush_ff  <= last && !trivial;
                  rmv_en_ff <= !early;
                  if (trivial) begin
                     res_val_ff  <= req_if.sample_value;
                     res_pos_ff  <= index_ff;
                     res_last_ff <= last;
                     res_err_ff  <= len_err;
                     state_ff    <= S_OUT;
                  end else begin
                     res_err_ff <= 1'b0;
                     good_ff[wr_ptr_ff] <= good;
                     if (good) begin
                        sum_ff   <= sum_ff + sext(req_if.sample_value);
                        count_ff <= count_ff + CW'(1);
                     end
                     cur_ptr_ff <= wr_ptr_ff;
                     wr_ptr_ff  <= (wr_ptr_ff == RW'(MAX_WINDOW - 1)) ? '0
                                                                      : wr_ptr_ff + RW'(1);
                     t_slot_ff  <= early ? RW'(t_i) : ring_back(wr_ptr_ff, w_eff >> 1);
                     res_pos_ff  <= POS_W'(t_i);
                     res_last_ff <= 1'b0;
                     start_ff    <= (next_emit_ff > start_base) ? next_emit_ff : start_base;
                     d_ff        <= w_eff - CW'(1);
                     snap_v_ff   <= 1'b0;
                     if (last) begin
                        state_ff <= F_EVAL;
                     end else if (t_i != t_n) begin
                        next_emit_ff <= POS_W'(t_i + 1);
                        state_ff     <= S_TRD;
                     end else begin
                        state_ff <= S_RMV;
                     end
                  end
               end
            end
            S_TRD: begin
               if (good_ff[t_slot_ff] && count_ff > CW'(1)) begin
                  div_quo_ff <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
                  div_neg_ff <= sum_ff[SUM_W-1];
                  div_den_ff <= count_ff;
                  div_rem_ff <= '0;
                  div_cnt_ff <= DCW'(SUM_W);
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_PASS;
               end
            end
            S_PASS: begin
               res_val_ff <= rdata_ff;
               state_ff   <= S_OUT;
            end
            S_DIV: begin
               if (div_cnt_ff == '0) begin
                  res_val_ff <= div_res[SAMPLE_BITS-1:0];
                  state_ff   <= S_OUT;
               end else begin
                  if (!div_trial[CW]) begin
                     div_rem_ff <= div_trial[CW-1:0];
                     div_quo_ff <= {div_quo_ff[SUM_W-2:0], 1'b1};
                  end else begin
                     div_rem_ff <= {div_rem_ff[CW-2:0], div_quo_ff[SUM_W-1]};
                     div_quo_ff <= {div_quo_ff[SUM_W-2:0], 1'b0};
                  end
                  div_cnt_ff <= div_cnt_ff - DCW'(1);
               end
            end
            S_OUT: begin
               if (out_free) begin
                  if (triv_ff) state_ff <= S_IDLE;
                  else if (flush_ff) state_ff <= F_NEXT;
                  else state_ff <= S_RMV;
               end
            end
            S_RMV: begin
               if (rmv_en_ff && good_ff[r_slot] && count_ff != '0) state_ff <= S_SUB;
               else state_ff <= S_IDLE;
            end
            S_SUB: begin
               sum_ff   <= sum_ff - sext(rdata_ff);
               count_ff <= count_ff - CW'(1);
               state_ff <= S_IDLE;
            end
            F_EVAL: begin
               // later window of the pair wins when it qualifies
               if (!d_ff[0] || f_cond) begin
                  snap_v_ff <= f_cond;
                  snap_s_ff <= sum_ff;
                  snap_c_ff <= count_ff;
               end
               if (good_ff[f_d_slot] && count_ff != '0) state_ff <= F_SUB;
               else state_ff <= F_EMIT;
            end
            F_SUB: begin
               sum_ff   <= sum_ff - sext(rdata_ff);
               count_ff <= count_ff - CW'(1);
               state_ff <= F_EMIT;
            end
            F_EMIT: begin
               if (f_complete && f_p >= start_ff) begin
                  res_pos_ff  <= f_p;
                  res_last_ff <= (f_m == '0);
                  if (snap_v_ff) begin
                     div_quo_ff <= snap_s_ff[SUM_W-1] ? SUM_W'(-snap_s_ff) : SUM_W'(snap_s_ff);
                     div_neg_ff <= snap_s_ff[SUM_W-1];
                     div_den_ff <= snap_c_ff;
                     div_rem_ff <= '0;
                     div_cnt_ff <= DCW'(SUM_W);
                     state_ff   <= S_DIV;
                  end else begin
                     state_ff <= S_PASS;
                  end
               end else begin
                  state_ff <= F_NEXT;
               end
            end
            F_NEXT: begin
               if (d_ff == '0) begin
                  good_ff      <= '0;
                  sum_ff       <= '0;
                  count_ff     <= '0;
                  next_emit_ff <= '0;
                  wr_ptr_ff    <= '0;
                  state_ff     <= S_IDLE;
               end else begin
                  d_ff     <= d_ff - CW'(1);
                  state_ff <= F_EVAL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.smoothed_value = out_val_ff;
   assign rsp_if.position       = out_pos_ff;
   assign rsp_if.last_of_run    = out_last_ff;
   assign rsp_if.length_error   = out_err_ff;

`include "masked_boxcar_smoother_unit_assert.svh"

   `MBS_ASSERT_NEXT(a_div_countdown, clock, reset,
      (state_ff == S_DIV && div_cnt_ff != '0), (div_cnt_ff == $past(div_cnt_ff) - DCW'(1)),
      "divider step count did not advance")
   `MBS_ASSERT_IMPL(a_flush_clears, clock, reset,
      (state_ff == S_IDLE && $past(state_ff) == F_NEXT),
      (count_ff == '0 && sum_ff == '0 && good_ff == '0), "flush left window state behind")
   `MBS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, (count_ff <= CW'(MAX_WINDOW)),
      "good count exceeds window capacity")

endmodule
